@@ src/kfr_pkg.sv @@
// Shared types and constants for the keyframe resync packet FIFO.
`timescale 1ns / 1ps
`default_nettype none
package kfr_pkg;

    typedef enum logic [2:0] {
        FUNC_PUSH      = 3'd0,
        FUNC_POP       = 3'd1,
        FUNC_FLUSH     = 3'd2,
        FUNC_SET_ABORT = 3'd3,
        FUNC_CLR_ABORT = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_ABORTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [7:0]  stream;
        logic        present;
        logic        key;
    } entry_t;

    typedef struct packed {
        status_t     status;
        logic        pop_ok;
        logic [6:0]  discarded;
        logic [6:0]  occupancy;
        logic        resyncing;
    } res_t;

    localparam logic [6:0] MAX_SIZE_RESET = 7'd64;
    localparam logic [7:0] VIDEO_STREAM   = 8'd0;

endpackage
`default_nettype wire

@@ src/kfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kfr_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ src/kfr_ctrl.sv @@
// Queue control: pointers, occupancy, resync and abort state, result register.
`timescale 1ns / 1ps
`default_nettype none
module kfr_ctrl #(
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     accept,
    input  wire logic [2:0]               func,
    input  wire logic [31:0]              packet_handle,
    input  wire logic                     has_packet,
    input  wire logic [7:0]               stream_index,
    input  wire logic                     key_flag,
    input  wire logic                     cfg_we,
    input  wire logic [6:0]               cfg_data,
    output logic                          wr_en,
    output logic      [$clog2(DEPTH)-1:0] wr_addr,
    output kfr_pkg::entry_t               wr_data,
    output logic      [$clog2(DEPTH)-1:0] rd_addr,
    output kfr_pkg::res_t                 res
);
    import kfr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          resync_reg, resync_next;
    logic          abort_reg, abort_next;
    logic [6:0]    max_size_reg;
    res_t          res_reg, res_next;

    logic [LW-1:0] max_ext, limit, count_ext;
    logic          key_video, limit_hit;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign max_ext   = LW'(max_size_reg);
    assign limit     = (max_ext > LW'(DEPTH)) ? LW'(DEPTH) : max_ext;
    assign count_ext = LW'(count_reg);
    assign limit_hit = count_ext >= limit;
    assign key_video = (stream_index == VIDEO_STREAM) && has_packet && key_flag;

    assign wr_data = '{handle: packet_handle, stream: stream_index,
                       present: has_packet, key: key_flag};
    assign rd_addr = rd_ptr_reg;

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        resync_next = resync_reg;
        abort_next  = abort_reg;
        wr_en       = 1'b0;
        wr_addr     = wr_ptr_reg;
        res_next    = '0;
        res_next.status = STAT_DONE;

        unique case (func_t'(func))
            FUNC_PUSH: begin
                if (resync_reg && !key_video) begin
                    res_next.status = STAT_DROPPED;
                end else if (resync_reg || limit_hit) begin
                    // restart from an empty queue
                    res_next.discarded = count_ext[6:0];
                    rd_ptr_next = '0;
                    if (key_video) begin
                        resync_next = 1'b0;
                        wr_en       = accept;
                        wr_addr     = '0;
                        wr_ptr_next = next_ptr('0);
                        count_next  = CW'(1);
                    end else begin
                        resync_next = 1'b1;
                        wr_ptr_next = '0;
                        count_next  = '0;
                        res_next.status = STAT_DROPPED;
                    end
                end else begin
                    wr_en       = accept;
                    wr_ptr_next = next_ptr(wr_ptr_reg);
                    count_next  = count_reg + 1'b1;
                end
            end
            FUNC_POP: begin
                if (abort_reg) begin
                    res_next.status = STAT_ABORTED;
                end else if (count_reg == '0) begin
                    res_next.status = STAT_EMPTY;
                end else begin
                    res_next.pop_ok = 1'b1;
                    rd_ptr_next = next_ptr(rd_ptr_reg);
                    count_next  = count_reg - 1'b1;
                end
            end
            FUNC_FLUSH: begin
                res_next.discarded = count_ext[6:0];
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                count_next  = '0;
            end
            FUNC_SET_ABORT: abort_next = 1'b1;
            FUNC_CLR_ABORT: abort_next = 1'b0;
            default: ;
        endcase

        res_next.occupancy = 7'(LW'(count_next));
        res_next.resyncing = resync_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
            resync_reg   <= 1'b0;
            abort_reg    <= 1'b0;
            max_size_reg <= MAX_SIZE_RESET;
        end else begin
            if (accept) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                count_reg  <= count_next;
                resync_reg <= resync_next;
                abort_reg  <= abort_next;
            end
            if (cfg_we) begin
                max_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> rd_ptr_reg == wr_ptr_reg)
        else $error("pointers disagree with occupancy");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_FLUSH) |=> count_reg == '0 && rd_ptr_reg == '0)
        else $error("flush left entries");

    a_resync_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func != FUNC_PUSH) |=> $stable(resync_reg))
        else $error("resync changed by non-push item");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_POP && !abort_reg && count_reg != '0)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not remove one entry");

endmodule
`default_nettype wire

@@ src/keyframe_resync_packet_fifo_core.sv @@
// Top level of the keyframe resync packet descriptor FIFO.
//
//  channel   | signals                                      | direction
//  s_        | s_valid/s_ready, func, handle, has, stream,  | in
//            | key                                          |
//  m_        | m_valid/m_ready, status, popped entry,       | out
//            | discarded count, occupancy, resyncing        |
//  cfg_      | cfg_valid/cfg_ready, cfg_max_size            | in
//
// Unless a result stalls, one item per cycle, each result in the next cycle.
// Popped data comes from the entry RAM's registered read port.
// Reset clears pointers, occupancy, resync and abort; max_size returns to 64.
// Entry RAM contents are not cleared; only written entries are ever popped.
// A stalled result holds and blocks input only while m_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_resync_packet_fifo_core #(
    parameter int DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [31:0] s_packet_handle,
    input  wire logic        s_has_packet,
    input  wire logic [7:0]  s_stream_index,
    input  wire logic        s_key_flag,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_out_handle,
    output logic             m_out_present,
    output logic [7:0]       m_out_stream,
    output logic             m_out_key,
    output logic [6:0]       m_discarded_count,
    output logic [6:0]       m_occupancy,
    output logic             m_resyncing,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_max_size
);
    import kfr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          accept;
    logic          m_valid_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_entry;
    res_t          res;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    kfr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .func          (s_func),
        .packet_handle (s_packet_handle),
        .has_packet    (s_has_packet),
        .stream_index  (s_stream_index),
        .key_flag      (s_key_flag),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_max_size),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .res           (res)
    );

    kfr_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign m_valid           = m_valid_reg;
    assign m_status          = res.status;
    assign m_out_handle      = res.pop_ok ? rd_entry.handle : '0;
    assign m_out_present     = res.pop_ok & rd_entry.present;
    assign m_out_stream      = res.pop_ok ? rd_entry.stream : '0;
    assign m_out_key         = res.pop_ok & rd_entry.key;
    assign m_discarded_count = res.discarded;
    assign m_occupancy       = res.occupancy;
    assign m_resyncing       = res.resyncing;

endmodule
`default_nettype wire
